// ----- hw/rtl/mctr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolour text cell renderer package
// Shared types, codes and store sizes for the character cell renderer.
// ----------------------------------------------------------------------------
package mctr_pkg;

  localparam int unsigned COLUMNS     = 40;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CellDepth   = 1024;
  localparam int unsigned GlyphDepth  = 2048;
  localparam int unsigned CellLimit   = (COLUMNS * ROWS < CellDepth) ?
                                        COLUMNS * ROWS : CellDepth;
  localparam int unsigned CellAddrW   = $clog2(CellDepth);
  localparam int unsigned GlyphAddrW  = $clog2(GlyphDepth);

  typedef enum logic [1:0] {
    OP_WR_CODE  = 2'd0,
    OP_WR_COLOR = 2'd1,
    OP_WR_GLYPH = 2'd2,
    OP_RENDER   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_BACKGROUND = 3'd0,
    CFG_MC_ONE     = 3'd1,
    CFG_MC_TWO     = 3'd2,
    CFG_BACK_ALPHA = 3'd3,
    CFG_FRONT_ALPHA = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PAIR_BACK = 2'b00,
    PAIR_MC1  = 2'b01,
    PAIR_MC2  = 2'b10,
    PAIR_CELL = 2'b11
  } pair_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] address;
    logic [7:0]  data;
    logic [2:0]  glyph_line;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_colors;
    logic [63:0] pixel_alpha;
    logic        is_multicolor;
  } out_item_t;

  typedef struct packed {
    logic [3:0] background_color;
    logic [3:0] multicolor_one;
    logic [3:0] multicolor_two;
    logic [7:0] back_alpha;
    logic [7:0] front_alpha;
  } cfg_t;

  typedef struct packed {
    logic       render;
    logic [3:0] cell_color;
    logic [7:0] glyph_bits;
  } stage2_t;

endpackage

// ----- hw/rtl/mctr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
module mctr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mctr_fetch.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell and glyph fetch
// Stage one reads the screen code and cell colour, stage two the glyph line.
// Each store is written in the stage that reads it, so beats keep their order.
// ----------------------------------------------------------------------------
module mctr_fetch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  mctr_pkg::in_item_t item_i,
  input  logic               adv1_i,
  input  logic               adv2_i,
  output logic               v1_o,
  output logic               v2_o,
  output mctr_pkg::stage2_t  s2_o
);
  import mctr_pkg::*;

  logic                  cell_ok;
  logic                  code_we;
  logic                  color_we;
  logic [7:0]            code_rd;
  logic [3:0]            color_rd;
  logic                  v1_q;
  logic                  v2_q;
  in_item_t              s1_q;
  logic                  ok1_q;
  logic                  render2_q;
  logic [3:0]            color2_q;
  logic                  glyph_we;
  logic [GlyphAddrW-1:0] glyph_raddr;
  logic [7:0]            glyph_rd;

  assign cell_ok  = item_i.address < 11'(CellLimit);
  assign code_we  = accept_i && cell_ok && (item_i.opcode == OP_WR_CODE);
  assign color_we = accept_i && cell_ok && (item_i.opcode == OP_WR_COLOR);

  mctr_ram #(.Width(8), .Depth(CellDepth)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (item_i.address[CellAddrW-1:0]),
    .wdata_i (item_i.data),
    .re_i    (adv1_i),
    .raddr_i (item_i.address[CellAddrW-1:0]),
    .rdata_o (code_rd)
  );

  mctr_ram #(.Width(4), .Depth(CellDepth)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (item_i.address[CellAddrW-1:0]),
    .wdata_i (item_i.data[3:0]),
    .re_i    (adv1_i),
    .raddr_i (item_i.address[CellAddrW-1:0]),
    .rdata_o (color_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1_i) begin
        v1_q <= accept_i;
      end
      if (adv2_i) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1_i) begin
      s1_q  <= item_i;
      ok1_q <= cell_ok;
    end
    if (adv2_i) begin
      render2_q <= ok1_q && (s1_q.opcode == OP_RENDER);
      color2_q  <= color_rd;
    end
  end

  assign glyph_we    = v1_q && adv2_i && (s1_q.opcode == OP_WR_GLYPH);
  assign glyph_raddr = GlyphAddrW'({code_rd, s1_q.glyph_line});

  mctr_ram #(.Width(8), .Depth(GlyphDepth)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (s1_q.address[GlyphAddrW-1:0]),
    .wdata_i (s1_q.data),
    .re_i    (adv2_i),
    .raddr_i (glyph_raddr),
    .rdata_o (glyph_rd)
  );

  assign v1_o = v1_q;
  assign v2_o = v2_q;
  assign s2_o = '{render: render2_q, cell_color: color2_q, glyph_bits: glyph_rd};

  a_v2_from_v1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v2_q) |-> $past(v1_q))
    else $error("stage two filled without a beat in stage one");

  a_hold_v1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv2_i) |=> v1_q)
    else $error("stalled beat lost from stage one");

endmodule

// ----- hw/rtl/mctr_shade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel shading stage
// Turns one glyph line and cell colour into eight palette indices and alphas.
// ----------------------------------------------------------------------------
module mctr_shade (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv3_i,
  input  logic                v2_i,
  input  mctr_pkg::stage2_t   s2_i,
  input  mctr_pkg::cfg_t      cfg_i,
  output logic                out_valid_o,
  output mctr_pkg::out_item_t out_item_o
);
  import mctr_pkg::*;

  logic      multi;
  out_item_t res_d;
  out_item_t res_q;
  logic      valid_q;
  logic [1:0] pair;
  logic [3:0] idx;
  logic [7:0] alpha;

  assign multi = s2_i.cell_color[3];

  always_comb begin
    res_d = '0;
    pair  = PAIR_BACK;
    idx   = '0;
    alpha = '0;
    for (int p = 0; p < 8; p++) begin
      if (multi) begin
        pair = s2_i.glyph_bits[(7 - 2 * (p / 2)) -: 2];
        case (pair)
          PAIR_BACK: begin
            idx   = cfg_i.background_color;
            alpha = cfg_i.back_alpha;
          end
          PAIR_MC1: begin
            idx   = cfg_i.multicolor_one;
            alpha = cfg_i.front_alpha;
          end
          PAIR_MC2: begin
            idx   = cfg_i.multicolor_two;
            alpha = cfg_i.front_alpha;
          end
          default: begin
            idx   = {1'b0, s2_i.cell_color[2:0]};
            alpha = cfg_i.front_alpha;
          end
        endcase
      end else begin
        idx   = s2_i.glyph_bits[7 - p] ? s2_i.cell_color : cfg_i.background_color;
        alpha = 8'hFF;
      end
      res_d.pixel_colors[(31 - 4 * p) -: 4] = idx;
      res_d.pixel_alpha[(63 - 8 * p) -: 8]  = alpha;
    end
    res_d.is_multicolor = multi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv3_i) begin
      valid_q <= v2_i && s2_i.render;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

  a_hires_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.is_multicolor) |-> (res_q.pixel_alpha == 64'hFFFF_FFFF_FFFF_FFFF))
    else $error("hires result with non-opaque pixel");

  a_result_from_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(v2_i && s2_i.render))
    else $error("result without a render beat behind it");

endmodule

// ----- hw/rtl/multicolor_text_cell_renderer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolour text cell renderer
// Three-stage pipeline: cell fetch, glyph fetch, pixel shading into an output
// register. Throughput is one beat per cycle while the output is not stalled;
// each stage holds while its successor is full and cannot advance.
// Reset clears the valid bits and sets the colour and alpha registers to their
// defaults; the three stores are undefined until written.
// ----------------------------------------------------------------------------
module multicolor_text_cell_renderer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mctr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mctr_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import mctr_pkg::*;

  cfg_t    cfg_q;
  logic    adv1;
  logic    adv2;
  logic    adv3;
  logic    accept;
  logic    v1;
  logic    v2;
  stage2_t s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{background_color: 4'h0, multicolor_one: 4'h0, multicolor_two: 4'h0,
                 back_alpha: 8'hFF, front_alpha: 8'hFF};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BACKGROUND:  cfg_q.background_color <= cfg_data_i[3:0];
        CFG_MC_ONE:      cfg_q.multicolor_one   <= cfg_data_i[3:0];
        CFG_MC_TWO:      cfg_q.multicolor_two   <= cfg_data_i[3:0];
        CFG_BACK_ALPHA:  cfg_q.back_alpha       <= cfg_data_i;
        CFG_FRONT_ALPHA: cfg_q.front_alpha      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv3       = !out_valid_o || !out_stall_i;
  assign adv2       = !v2 || adv3;
  assign adv1       = !v1 || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  mctr_fetch u_fetch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .adv1_i   (adv1),
    .adv2_i   (adv2),
    .v1_o     (v1),
    .v2_o     (v2),
    .s2_o     (s2)
  );

  mctr_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv3_i      (adv3),
    .v2_i        (v2),
    .s2_i        (s2),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1 && v2 && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1 && !v2) |-> !in_stall_o)
    else $error("input stalled while the fetch stages are empty");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multicolour text cell renderer testbench
// Drives store writes and render requests through the valid/stall input
// channel, predicts every rendered glyph line from a shadow copy of the
// screen, colour and glyph stores and of the palette registers, and checks
// each output beat field by field. Both sides idle at random, the output is
// held off for a long stretch once, and the palette is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import mctr_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseBeats    = 155;
  localparam logic [2:0]  CfgSpare      = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Shadow copies of the stores and palette.
  logic [7:0] code_mem  [CellDepth];
  logic [3:0] color_mem [CellDepth];
  logic [7:0] glyph_mem [GlyphDepth];
  bit         code_set  [CellDepth];
  bit         color_set [CellDepth];
  bit         glyph_set [GlyphDepth];
  bit         cell_ready [CellDepth];
  int unsigned ready_cells[$];
  cfg_t       palette = '{4'h0, 4'h0, 4'h0, 8'hFF, 8'hFF};

  out_item_t  expected_lines[$];
  int unsigned beats_sent = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit         tx_idle = 1'b0;
  bit         rx_idle = 1'b0;
  int         rx_wait = 0;
  int         rx_hold = 0;

  multicolor_text_cell_renderer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic in_item_t make_beat(opcode_e op, int unsigned addr, int unsigned val,
                                         int unsigned line);
    in_item_t b;
    b.opcode     = op;
    b.address    = addr[10:0];
    b.data       = val[7:0];
    b.glyph_line = line[2:0];
    return b;
  endfunction

  function automatic out_item_t shade_line(in_item_t b);
    out_item_t  r;
    logic [9:0] cell_idx;
    logic [7:0] bits;
    logic [3:0] cc;
    logic [3:0] idx;
    logic [7:0] alpha;
    logic [1:0] two;
    cell_idx = b.address[9:0];
    bits = glyph_mem[{code_mem[cell_idx], b.glyph_line}];
    cc = color_mem[cell_idx];
    r.is_multicolor = cc[3];
    for (int p = 0; p < 8; p++) begin
      if (cc[3]) begin
        two = bits[7 - 2 * (p / 2) -: 2];
        case (pair_e'(two))
          PAIR_BACK: begin
            idx = palette.background_color;
            alpha = palette.back_alpha;
          end
          PAIR_MC1: begin
            idx = palette.multicolor_one;
            alpha = palette.front_alpha;
          end
          PAIR_MC2: begin
            idx = palette.multicolor_two;
            alpha = palette.front_alpha;
          end
          default: begin
            idx = {1'b0, cc[2:0]};
            alpha = palette.front_alpha;
          end
        endcase
      end else begin
        idx = bits[7 - p] ? cc : palette.background_color;
        alpha = 8'hFF;
      end
      r.pixel_colors[31 - 4 * p -: 4] = idx;
      r.pixel_alpha[63 - 8 * p -: 8] = alpha;
    end
    return r;
  endfunction

  function automatic void track_beat(in_item_t b);
    logic [9:0] cell_idx;
    bit         on_grid;
    cell_idx = b.address[9:0];
    on_grid = b.address < CellLimit;
    case (opcode_e'(b.opcode))
      OP_WR_CODE: begin
        if (on_grid) begin
          code_mem[cell_idx] = b.data;
          code_set[cell_idx] = 1'b1;
        end
      end
      OP_WR_COLOR: begin
        if (on_grid) begin
          color_mem[cell_idx] = b.data[3:0];
          color_set[cell_idx] = 1'b1;
        end
      end
      OP_WR_GLYPH: begin
        glyph_mem[b.address] = b.data;
        glyph_set[b.address] = 1'b1;
      end
      default: begin
        if (on_grid) expected_lines.push_back(shade_line(b));
      end
    endcase
    if (on_grid && code_set[cell_idx] && color_set[cell_idx] && !cell_ready[cell_idx]) begin
      cell_ready[cell_idx] = 1'b1;
      ready_cells.push_back(32'(cell_idx));
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_beat(in_item_t b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= b;
    do @(posedge clk_i); while (in_stall);
    track_beat(b);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_lines.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic write_palette(cfg_t val);
    put_reg(CFG_BACKGROUND, {4'h0, val.background_color});
    put_reg(CFG_MC_ONE, {4'h0, val.multicolor_one});
    put_reg(CFG_MC_TWO, {4'h0, val.multicolor_two});
    put_reg(CFG_BACK_ALPHA, val.back_alpha);
    put_reg(CFG_FRONT_ALPHA, val.front_alpha);
    put_reg(CfgSpare, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    palette = val;
  endtask

  task automatic random_beat(int unsigned render_pct);
    in_item_t    b;
    int unsigned cell_idx;
    int unsigned pick;
    logic [10:0] glyph_addr;
    b.address = 11'($urandom_range(0, 2047));
    b.data = 8'($urandom_range(0, 255));
    b.glyph_line = 3'($urandom_range(0, 7));
    cell_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CellLimit - 1) :
                                             $urandom_range(0, 47);
    pick = $urandom_range(0, 99);
    if (pick < render_pct && ready_cells.size() != 0) begin
      cell_idx = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
      glyph_addr = {code_mem[cell_idx], b.glyph_line};
      if (!glyph_set[glyph_addr]) begin
        send_beat(make_beat(OP_WR_GLYPH, glyph_addr, $urandom_range(0, 255),
                            $urandom_range(0, 7)));
      end
      b.opcode = OP_RENDER;
      b.address = 11'(cell_idx);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        b.opcode = OP_WR_CODE;
        b.address = 11'(cell_idx);
      end else if (pick < 60) begin
        b.opcode = OP_WR_COLOR;
        b.address = 11'(cell_idx);
      end else if (pick < 85) begin
        b.opcode = OP_WR_GLYPH;
      end else if (pick < 95) begin
        b.opcode = ($urandom_range(0, 1) == 0) ? OP_WR_CODE : OP_WR_COLOR;
        b.address = 11'($urandom_range(CellLimit, 2047));
      end else begin
        b.opcode = OP_RENDER;
        b.address = 11'($urandom_range(CellLimit, 2047));
      end
    end
    send_beat(b);
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_beat(make_beat(OP_WR_CODE, 0, 8'h00, 0));
    send_beat(make_beat(OP_WR_CODE, CellLimit - 1, 8'hFF, 5));
    send_beat(make_beat(OP_WR_COLOR, 0, 8'hF9, 0));
    send_beat(make_beat(OP_WR_COLOR, CellLimit - 1, 8'hA7, 2));
    send_beat(make_beat(OP_WR_GLYPH, 0, 8'hE4, 0));
    send_beat(make_beat(OP_WR_GLYPH, 1, 8'h1B, 7));
    send_beat(make_beat(OP_WR_GLYPH, 2, 8'h00, 0));
    send_beat(make_beat(OP_WR_GLYPH, GlyphDepth - 1, 8'hA5, 0));
    send_beat(make_beat(OP_WR_GLYPH, GlyphDepth - 8, 8'hFF, 3));
    send_beat(make_beat(OP_RENDER, 0, 8'h00, 0));
    send_beat(make_beat(OP_RENDER, 0, 8'hFF, 1));
    send_beat(make_beat(OP_RENDER, 0, 8'h00, 2));
    send_beat(make_beat(OP_RENDER, CellLimit - 1, 8'h00, 7));
    send_beat(make_beat(OP_RENDER, CellLimit - 1, 8'h55, 0));
    // Writes off the grid must not land on an aliased cell.
    send_beat(make_beat(OP_WR_CODE, CellDepth, 8'h5A, 0));
    send_beat(make_beat(OP_WR_CODE, CellLimit, 8'h01, 0));
    send_beat(make_beat(OP_WR_COLOR, CellDepth + CellLimit - 1, 8'h08, 0));
    send_beat(make_beat(OP_WR_COLOR, 2047, 8'hFF, 7));
    send_beat(make_beat(OP_RENDER, CellLimit, 8'h00, 0));
    send_beat(make_beat(OP_RENDER, 2047, 8'hFF, 7));
    send_beat(make_beat(OP_RENDER, 0, 8'h00, 0));
    send_beat(make_beat(OP_RENDER, CellLimit - 1, 8'h00, 7));
    drain();
  endtask

  task automatic test_palette_phases();
    cfg_t        setting;
    int unsigned start;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setting = '{4'hF, 4'hF, 4'hF, 8'hFF, 8'hFF};
        1: setting = '0;
        2: setting = '{4'h3, 4'hA, 4'h5, 8'h00, 8'hFF};
        3: setting = '{4'hC, 4'h6, 4'h9, 8'hFF, 8'h00};
        default: setting = 28'($urandom);
      endcase
      tx_idle = (phase % 4) != 1;
      rx_idle = (phase % 4) != 2;
      write_palette(setting);
      start = beats_sent;
      while (beats_sent - start < PhaseBeats) random_beat(45);
      drain();
    end
  endtask

  task automatic test_output_hold();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    @(negedge clk_i);
    rx_hold = HoldCycles;
    @(posedge clk_i);
    repeat (48) random_beat(100);
    drain();
  endtask

  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (20) random_beat(45);
    drain();
    repeat (20) random_beat(45);
    drain();
  endtask

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
    else if (rx_wait > 0) rx_wait--;
    if (rx_hold > 0) rx_hold--;
    out_stall <= (rx_wait > 0) || (rx_hold > 0);
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("beat with no render pending", 64'(out_item.pixel_colors), '0);
      end else begin
        want = expected_lines.pop_front();
        if (out_item.pixel_colors !== want.pixel_colors)
          report_mismatch("pixel_colors", 64'(out_item.pixel_colors),
                          64'(want.pixel_colors));
        if (out_item.pixel_alpha !== want.pixel_alpha)
          report_mismatch("pixel_alpha", out_item.pixel_alpha, want.pixel_alpha);
        if (out_item.is_multicolor !== want.is_multicolor)
          report_mismatch("is_multicolor", 64'(out_item.is_multicolor),
                          64'(want.is_multicolor));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_palette_phases();
    test_output_hold();
    test_sender_pause();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
